// File: design/lhe_pkg.sv
// Shared types and constants for the latency histogram engine.
`default_nettype none

package lhe_pkg;

	localparam int NUM_THRESH = 7;
	localparam int TH_IW      = 3;
	localparam int TH_W       = 32;
	localparam int CNT_W      = 48;
	localparam int SUM_W      = 64;
	localparam int VAL_W      = 64;

	localparam logic [TH_W-1:0] LIMIT_INF = 32'hFFFF_FFFF;

	localparam logic [TH_W-1:0] TH_RESET [NUM_THRESH] = '{
		32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000
	};

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_DUMP   = 1'b1;

	localparam logic [1:0] MT_COUNT  = 2'd0;
	localparam logic [1:0] MT_SUM    = 2'd1;
	localparam logic [1:0] MT_BUCKET = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  hist_select;
		logic [31:0] wait_us;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  metric_type;
		logic [31:0] bucket_limit_us;
		logic        limit_infinite;
		logic [63:0] metric_value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} stat_t;

endpackage

`default_nettype wire

// File: design/lhe_ram.sv
// Synchronous memory with a registered read and per-entry valid bits that read as zero.
`default_nettype none

module lhe_ram #(
	parameter int W  = 48,
	parameter int AW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	localparam int DEPTH = 2 ** AW;

	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [W-1:0]     rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_q & {W{rd_vld_q}};

endmodule

`default_nettype wire

// File: design/lhe_thresh.sv
// Threshold registers, bucket selection for a latency and limit lookup for dumps.
`default_nettype none

module lhe_thresh #(
	parameter int BUCKETS = 8,
	parameter int BW      = 3
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [lhe_pkg::TH_IW-1:0] cfg_index,
	input  wire logic [lhe_pkg::TH_W-1:0]  cfg_data,
	input  wire logic [lhe_pkg::TH_W-1:0]  lat,
	output logic      [BW-1:0]             bucket,
	input  wire logic [lhe_pkg::TH_IW-1:0] lim_idx,
	output logic      [lhe_pkg::TH_W-1:0]  limit
);

	import lhe_pkg::*;

	logic [TH_W-1:0] th_q [NUM_THRESH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THRESH; i++) begin
				th_q[i] <= TH_RESET[i];
			end
		end else if (cfg_we && (cfg_index < TH_IW'(NUM_THRESH))) begin
			th_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		bucket = BW'(BUCKETS - 1);
		for (int b = NUM_THRESH - 1; b >= 0; b--) begin
			if ((b < BUCKETS - 1) && (lat < th_q[b])) begin
				bucket = BW'(b);
			end
		end
	end

	always_comb begin
		if (lim_idx < TH_IW'(NUM_THRESH)) begin
			limit = th_q[lim_idx];
		end else begin
			limit = LIMIT_INF;
		end
	end

endmodule

`default_nettype wire

// File: design/latency_histogram_engine_top.sv
// Top level of the latency histogram engine: record pipeline and dump sequencer.
//
// Channel   Signals                         Beat taken when
// command   start, busy, cmd                start && !busy
// result    result_valid, result            result_valid (one cycle, no stall)
// config    cfg_we, cfg_index, cfg_data     cfg_we
//
// A record beat is taken while idle; records can be accepted back to back, the
// read-modify-write of the counter memories forwards the previous write.
// A dump beat holds busy through its whole read sequence, one memory read per result,
// and its results follow the reads through the memory read register and the result register.
// Reset clears thresholds to their defaults and all counters to zero at once.
// The result side has no backpressure.
`default_nettype none

module latency_histogram_engine_top #(
	parameter int BUCKETS    = 8,
	parameter int HISTOGRAMS = 3
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire lhe_pkg::cmd_t             cmd,
	output logic                           result_valid,
	output lhe_pkg::result_t               result,
	input  wire logic                      cfg_we,
	input  wire logic [lhe_pkg::TH_IW-1:0] cfg_index,
	input  wire logic [lhe_pkg::TH_W-1:0]  cfg_data
);

	import lhe_pkg::*;

	localparam int BW   = $clog2(BUCKETS);
	localparam int HW   = (HISTOGRAMS > 1) ? $clog2(HISTOGRAMS) : 1;
	localparam int CW   = $clog2(BUCKETS + 2);
	localparam int ST_W = SUM_W + CNT_W;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [HW-1:0] sel_q;

	logic accept, in_range, rec_go, dump_go;
	logic [HW-1:0] hsel;
	logic [BW-1:0] pick;
	logic [BW-1:0] run_bidx;

	logic [HW+BW-1:0] bkt_raddr;
	logic [HW-1:0]    st_raddr;
	logic [CNT_W-1:0] bkt_rdata;
	logic [ST_W-1:0]  st_rdata;

	logic             rec_s1;
	logic [HW+BW-1:0] bkt_addr_s1;
	logic [HW-1:0]    hist_s1;
	logic [31:0]      lat_s1;
	logic             dmp_s1;
	logic [CW-1:0]    cnt_s1;

	logic             fwd_vld_q;
	logic [HW+BW-1:0] fwd_bkt_addr_q;
	logic [HW-1:0]    fwd_hist_q;
	logic [CNT_W-1:0] fwd_bkt_q;
	stat_t            fwd_st_q;

	logic [CNT_W-1:0] bkt_cur, bkt_new;
	stat_t            st_cur, st_mem, st_new;

	logic [VAL_W-1:0] acc_q, acc_next;
	logic [BW-1:0]    bidx_s1;
	logic             bkt_last_s1;
	logic [TH_W-1:0]  th_limit;

	assign hsel     = cmd.hist_select[HW-1:0];
	assign in_range = {1'b0, cmd.hist_select} < 3'(HISTOGRAMS);
	assign accept   = start && !busy;
	assign rec_go   = accept && in_range && (cmd.kind == KIND_RECORD);
	assign dump_go  = accept && in_range && (cmd.kind == KIND_DUMP);
	assign run_bidx = BW'(cnt_q - CW'(2));

	lhe_thresh #(
		.BUCKETS (BUCKETS),
		.BW      (BW)
	) u_thresh (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.lat       (cmd.wait_us),
		.bucket    (pick),
		.lim_idx   (TH_IW'(bidx_s1)),
		.limit     (th_limit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b0;
		bkt_raddr = {hsel, pick};
		st_raddr  = hsel;
		case (state_q)
			ST_IDLE: begin
				if (dump_go) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				busy      = 1'b1;
				bkt_raddr = {sel_q, run_bidx};
				st_raddr  = sel_q;
				if (cnt_q == CW'(BUCKETS + 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rec_s1    <= 1'b0;
			dmp_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (dump_go) begin
				cnt_q <= '0;
			end else if (state_q == ST_DUMP) begin
				cnt_q <= cnt_q + CW'(1);
			end
			rec_s1    <= rec_go;
			dmp_s1    <= (state_q == ST_DUMP);
			fwd_vld_q <= rec_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dump_go) begin
			sel_q <= hsel;
		end
		bkt_addr_s1    <= bkt_raddr;
		hist_s1        <= st_raddr;
		lat_s1         <= cmd.wait_us;
		cnt_s1         <= cnt_q;
		fwd_bkt_addr_q <= bkt_addr_s1;
		fwd_hist_q     <= hist_s1;
		fwd_bkt_q      <= bkt_new;
		fwd_st_q       <= st_new;
	end

	assign st_mem = stat_t'(st_rdata);

	always_comb begin
		bkt_cur = bkt_rdata;
		if (fwd_vld_q && (fwd_bkt_addr_q == bkt_addr_s1)) begin
			bkt_cur = fwd_bkt_q;
		end
		st_cur = st_mem;
		if (fwd_vld_q && (fwd_hist_q == hist_s1)) begin
			st_cur = fwd_st_q;
		end
		bkt_new    = bkt_cur + CNT_W'(1);
		st_new.cnt = st_cur.cnt + CNT_W'(1);
		st_new.sum = st_cur.sum + SUM_W'(lat_s1);
	end

	lhe_ram #(
		.W  (CNT_W),
		.AW (HW + BW)
	) u_bkt_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (rec_s1),
		.waddr  (bkt_addr_s1),
		.wdata  (bkt_new),
		.raddr  (bkt_raddr),
		.rdata  (bkt_rdata)
	);

	lhe_ram #(
		.W  (ST_W),
		.AW (HW)
	) u_st_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (rec_s1),
		.waddr  (hist_s1),
		.wdata  (ST_W'(st_new)),
		.raddr  (st_raddr),
		.rdata  (st_rdata)
	);

	assign bidx_s1     = BW'(cnt_s1 - CW'(2));
	assign bkt_last_s1 = (bidx_s1 == BW'(BUCKETS - 1));
	assign acc_next    = ((bidx_s1 == '0) ? '0 : acc_q) + VAL_W'(bkt_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= dmp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dmp_s1) begin
			case (cnt_s1)
				CW'(0): begin
					result.metric_type     <= MT_COUNT;
					result.bucket_limit_us <= '0;
					result.limit_infinite  <= 1'b0;
					result.metric_value    <= VAL_W'(st_mem.cnt);
					result.last            <= 1'b0;
				end
				CW'(1): begin
					result.metric_type     <= MT_SUM;
					result.bucket_limit_us <= '0;
					result.limit_infinite  <= 1'b0;
					result.metric_value    <= st_mem.sum;
					result.last            <= 1'b0;
				end
				default: begin
					acc_q                  <= acc_next;
					result.metric_type     <= MT_BUCKET;
					result.bucket_limit_us <= bkt_last_s1 ? LIMIT_INF : th_limit;
					result.limit_infinite  <= bkt_last_s1;
					result.metric_value    <= acc_next;
					result.last            <= bkt_last_s1;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_dump_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP && cnt_q == CW'(BUCKETS + 1)) |=> (state_q == ST_IDLE))
		else $error("dump sequence did not end after its last read");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_s1 && dmp_s1))
		else $error("record update overlaps a dump read");

	a_last_inf: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> (result.limit_infinite
			&& result.metric_type == MT_BUCKET))
		else $error("final dump beat is not the unbounded bucket");

	a_rec_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rec_s1 |-> $past(state_q == ST_IDLE))
		else $error("record accepted during a dump");
`endif

endmodule

`default_nettype wire

// File: tb/tb_latency_histogram_engine_top.sv
// Testbench for the latency histogram engine: directed table, random commands, result scoreboard.
`default_nettype none

module tb_latency_histogram_engine_top;
	import lhe_pkg::*;

	localparam int BUCKETS     = 8;
	localparam int HISTS       = 3;
	localparam int DRAIN       = 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {
		LIM_ASCEND,
		LIM_ZERO,
		LIM_FULL,
		LIM_SHUFFLE,
		LIM_DEFAULT
	} lim_mode_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        typed;
		logic [63:0] count_exp;
		logic [63:0] sum_exp;
		logic [63:0] cum_exp;
	} step_row_t;

	localparam int N_ROWS = 21;
	localparam step_row_t DIRECTED [N_ROWS] = '{
		'{'{KIND_DUMP,   2'd0, 32'd0},           1'b1, 64'd0, 64'd0, 64'd0},
		'{'{KIND_DUMP,   2'd3, 32'd0},           1'b1, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd0, 32'd0},           1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_DUMP,   2'd0, 32'hFFFF_FFFF},   1'b1, 64'd1, 64'd0, 64'd1},
		'{'{KIND_RECORD, 2'd0, 32'd1},           1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd0, 32'd9},           1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd0, 32'd10},          1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd0, 32'd999999},      1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd0, 32'd1000000},     1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd0, 32'hFFFF_FFFF},   1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd1, 32'hFFFF_FFFF},   1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd1, 32'hFFFF_FFFF},   1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd2, 32'd99},          1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd2, 32'd100},         1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd3, 32'd5},           1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_DUMP,   2'd3, 32'h5555_AAAA},   1'b1, 64'd0, 64'd0, 64'd0},
		'{'{KIND_DUMP,   2'd0, 32'd0},           1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_DUMP,   2'd1, 32'd0},           1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_DUMP,   2'd2, 32'd0},           1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_RECORD, 2'd0, 32'd0},           1'b0, 64'd0, 64'd0, 64'd0},
		'{'{KIND_DUMP,   2'd0, 32'd0},           1'b0, 64'd0, 64'd0, 64'd0}
	};

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	cmd_t           cmd;
	logic           result_valid;
	result_t        result;
	logic           cfg_we;
	logic [TH_IW-1:0] cfg_index;
	logic [TH_W-1:0]  cfg_data;

	logic [TH_W-1:0]  bound [BUCKETS-1];
	logic [CNT_W-1:0] bucket_tally [HISTS][BUCKETS];
	logic [CNT_W-1:0] sample_tally [HISTS];
	logic [SUM_W-1:0] latency_total [HISTS];

	result_t due_metrics [$];
	result_t head;
	int      errors;
	int      n_cmds;
	int      n_dumps;
	int      n_beats;
	int      n_settings;
	int      cycles;

	latency_histogram_engine_top #(
		.BUCKETS(BUCKETS),
		.HISTOGRAMS(HISTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_beat(input logic [1:0] mt, input logic [31:0] lim,
			input logic inf, input logic [63:0] val, input logic fin);
		result_t r;
		r.metric_type     = mt;
		r.bucket_limit_us = lim;
		r.limit_infinite  = inf;
		r.metric_value    = val;
		r.last            = fin;
		due_metrics.push_back(r);
	endfunction

	function automatic void tally_command(input cmd_t c);
		int slot;
		logic [63:0] running;
		if (c.hist_select >= HISTS)
			return;
		if (c.kind == KIND_RECORD) begin
			slot = BUCKETS - 1;
			for (int b = BUCKETS - 2; b >= 0; b--)
				if (c.wait_us < bound[b])
					slot = b;
			bucket_tally[c.hist_select][slot] += 48'd1;
			sample_tally[c.hist_select] += 48'd1;
			latency_total[c.hist_select] += 64'(c.wait_us);
		end else begin
			push_beat(MT_COUNT, 32'd0, 1'b0, 64'(sample_tally[c.hist_select]), 1'b0);
			push_beat(MT_SUM, 32'd0, 1'b0, latency_total[c.hist_select], 1'b0);
			running = 64'd0;
			for (int b = 0; b < BUCKETS; b++) begin
				running += 64'(bucket_tally[c.hist_select][b]);
				if (b == BUCKETS - 1)
					push_beat(MT_BUCKET, LIMIT_INF, 1'b1, running, 1'b1);
				else
					push_beat(MT_BUCKET, bound[b], 1'b0, running, 1'b0);
			end
		end
	endfunction

	function automatic void push_typed(input step_row_t row);
		if (row.cmd.kind != KIND_DUMP || row.cmd.hist_select >= HISTS)
			return;
		push_beat(MT_COUNT, 32'd0, 1'b0, row.count_exp, 1'b0);
		push_beat(MT_SUM, 32'd0, 1'b0, row.sum_exp, 1'b0);
		for (int b = 0; b < BUCKETS; b++) begin
			if (b == BUCKETS - 1)
				push_beat(MT_BUCKET, LIMIT_INF, 1'b1, row.cum_exp, 1'b1);
			else
				push_beat(MT_BUCKET, TH_RESET[b], 1'b0, row.cum_exp, 1'b0);
		end
	endfunction

	function automatic logic [31:0] pick_latency();
		int unsigned r;
		int unsigned t;
		r = $urandom_range(9);
		t = $urandom_range(BUCKETS - 2);
		case (r)
			0, 1, 2: return bound[t] + 32'($urandom_range(2)) - 32'd1;
			3, 4:    return 32'($urandom_range(20));
			5:       return 32'hFFFF_FFFF;
			6:       return 32'($urandom_range(2000000));
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.kind        = ($urandom_range(5) == 0) ? KIND_DUMP : KIND_RECORD;
		c.hist_select = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(HISTS - 1));
		c.wait_us     = pick_latency();
		return c;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] e,
			input logic [63:0] a);
		if (a !== e) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			n_beats++;
			if (due_metrics.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual %0h",
					$time, result);
			end else begin
				head = due_metrics.pop_front();
				check_field("metric_type", 64'(head.metric_type), 64'(result.metric_type));
				check_field("bucket_limit_us", 64'(head.bucket_limit_us),
					64'(result.bucket_limit_us));
				check_field("limit_infinite", 64'(head.limit_infinite),
					64'(result.limit_infinite));
				check_field("metric_value", head.metric_value, result.metric_value);
				check_field("last", 64'(head.last), 64'(result.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d result beats outstanding", $time,
				due_metrics.size());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_cmd(input cmd_t c, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		n_cmds++;
		if (c.kind == KIND_DUMP)
			n_dumps++;
	endtask

	task automatic quiesce();
		start <= 1'b0;
		while (due_metrics.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic load_limits(input lim_mode_t mode);
		logic [31:0] v;
		logic [31:0] prev;
		quiesce();
		prev = 32'd0;
		for (int i = 0; i < 8; i++) begin
			case (mode)
				LIM_ASCEND:  v = prev + 32'($urandom_range(1, 3000));
				LIM_ZERO:    v = 32'd0;
				LIM_FULL:    v = 32'hFFFF_FFFF;
				LIM_SHUFFLE: v = 32'($urandom_range(5000));
				default:     v = (i < NUM_THRESH) ? TH_RESET[i] : 32'd0;
			endcase
			if (i >= NUM_THRESH)
				v = $urandom;
			prev      = v;
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= v;
			@(posedge clk);
			if (i < NUM_THRESH)
				bound[i] = v;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	initial begin : stimulus
		lim_mode_t mode;
		int        idle_pct;
		int        count;
		cmd_t      c;
		errors     = 0;
		n_cmds     = 0;
		n_dumps    = 0;
		n_beats    = 0;
		n_settings = 1;
		cycles     = 0;
		for (int i = 0; i < BUCKETS - 1; i++)
			bound[i] = TH_RESET[i];
		for (int h = 0; h < HISTS; h++) begin
			sample_tally[h]  = '0;
			latency_total[h] = '0;
			for (int b = 0; b < BUCKETS; b++)
				bucket_tally[h][b] = '0;
		end
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			send_cmd(DIRECTED[i].cmd, 32);
			if (DIRECTED[i].typed)
				push_typed(DIRECTED[i]);
			else
				tally_command(DIRECTED[i].cmd);
		end

		for (int s = 0; s < 6; s++) begin
			case (s)
				0: begin mode = LIM_ASCEND;  idle_pct = 32; count = 40; end
				1: begin mode = LIM_ZERO;    idle_pct = 32; count = 30; end
				2: begin mode = LIM_FULL;    idle_pct = 86; count = 30; end
				3: begin mode = LIM_SHUFFLE; idle_pct = 86; count = 40; end
				4: begin mode = LIM_DEFAULT; idle_pct = 0;  count = 40; end
				default: begin mode = LIM_SHUFFLE; idle_pct = 0; count = 30; end
			endcase
			load_limits(mode);
			for (int k = 0; k < count; k++) begin
				c = random_cmd();
				send_cmd(c, idle_pct);
				tally_command(c);
			end
		end

		start <= 1'b0;
		while (due_metrics.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Covered %0d commands, %0d of them dumps, under %0d threshold settings.",
			n_cmds, n_dumps, n_settings);
		$display("Checked %0d result beats with %0d mismatches.", n_beats, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
